[sv/mpte_pkg.sv]
// shared types and constants for the memory pattern test engine
// no dependencies; imported by mpte_front, mpte_back and the top level
package mpte_pkg;

    localparam int unsigned CFG_WIDTH  = 16;
    localparam int unsigned DATA_WIDTH = 8;
    localparam int unsigned OUT_ADDR_W = 16;
    localparam int unsigned OUT_CNT_W  = 9;
    localparam int unsigned STATE_W    = 3;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 112;

    // configuration register indexes
    localparam logic CFG_START_ADDRESS = 1'b0;
    localparam logic CFG_END_ADDRESS   = 1'b1;

    localparam logic [CFG_WIDTH-1:0] START_ADDRESS_RST = 16'h8000;
    localparam logic [CFG_WIDTH-1:0] END_ADDRESS_RST   = 16'hBFFF;

    typedef enum logic
    {
        OP_START    = 1'b0,
        OP_READBACK = 1'b1
    } op_t;

    typedef enum logic [STATE_W-1:0]
    {
        RS_IDLE    = 3'd0,
        RS_RUN     = 3'd1,
        RS_CLEAN   = 3'd2,
        RS_ERRORS  = 3'd3,
        RS_CANCEL  = 3'd4
    } run_state_t;

    typedef struct packed
    {
        op_t                   op;
        logic [DATA_WIDTH-1:0] data;
    } cmd_t;

    function automatic logic [DATA_WIDTH-1:0] pattern_of(input logic [1:0] step);
        logic [DATA_WIDTH-1:0] p;
        case (step)
            2'd0:    p = 8'h00;
            2'd1:    p = 8'hFF;
            2'd2:    p = 8'hAA;
            2'd3:    p = 8'h55;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

[sv/memory_pattern_test_engine_top.sv]
// memory pattern test engine: transactions pass the command queue in mpte_front
// and the result register in mpte_back, one per cycle unless m_axis_tready stalls;
// a 2-entry command queue lets the input side keep going while a result waits
// asynchronous active-low reset: idle, counters zero, start 0x8000, end 0xBFFF
// depends on mpte_pkg, mpte_front, mpte_back
module memory_pattern_test_engine_top
#(
    parameter int ADDRESS_WIDTH = 16,
    parameter int ERROR_LIMIT   = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [mpte_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mpte_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // read_data
    input  logic                                  s_axis_tuser,  // action
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // request_address, request_pattern, run_state, total_errors,
    // bit0_errors .. bit7_errors, zero pad
    output logic [mpte_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import mpte_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_ADDR_W - DATA_WIDTH - STATE_W
                           - OUT_CNT_W - DATA_WIDTH * OUT_CNT_W;

    logic                            cmd_valid, cmd_ready;
    cmd_t                            cmd;
    logic [OUT_ADDR_W-1:0]           res_address;
    logic [DATA_WIDTH-1:0]           res_pattern;
    logic [STATE_W-1:0]              res_state;
    logic [OUT_CNT_W-1:0]            res_total;
    logic [DATA_WIDTH*OUT_CNT_W-1:0] res_bits;

    mpte_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mpte_back
    #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH),
        .ERROR_LIMIT   (ERROR_LIMIT)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_address (res_address),
        .res_pattern (res_pattern),
        .res_state   (res_state),
        .res_total   (res_total),
        .res_bits    (res_bits)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, res_bits, res_total, res_state,
                           res_pattern, res_address};

endmodule

[sv/mpte_front.sv]
// front end: accepts stream transactions, decodes the action and queues commands
// depends on mpte_pkg
module mpte_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_action,
    input  logic [mpte_pkg::DATA_WIDTH-1:0]     in_data,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output mpte_pkg::cmd_t                      cmd
);
    import mpte_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       in_cmd;

    always_comb
    begin
        in_cmd.op   = in_action ? OP_READBACK : OP_START;
        in_cmd.data = in_data;
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[sv/mpte_back.sv]
// back end: runs the test sequence, counts bit errors and holds the result register
// depends on mpte_pkg
module mpte_back
#(
    parameter int ADDRESS_WIDTH = 16,
    parameter int ERROR_LIMIT   = 256
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic                                        cfg_index,
    input  logic [mpte_pkg::CFG_WIDTH-1:0]              cfg_wdata,
    input  logic                                        cmd_valid,
    output logic                                        cmd_ready,
    input  mpte_pkg::cmd_t                              cmd,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output logic [mpte_pkg::OUT_ADDR_W-1:0]             res_address,
    output logic [mpte_pkg::DATA_WIDTH-1:0]             res_pattern,
    output logic [mpte_pkg::STATE_W-1:0]                res_state,
    output logic [mpte_pkg::OUT_CNT_W-1:0]              res_total,
    output logic [mpte_pkg::DATA_WIDTH*mpte_pkg::OUT_CNT_W-1:0] res_bits
);
    import mpte_pkg::*;

    localparam int AW   = ADDRESS_WIDTH;
    localparam int CW   = $clog2(ERROR_LIMIT + 1);
    localparam int CMPW = CW + 4;
    localparam logic [CW-1:0] LIMIT = CW'(ERROR_LIMIT);

    logic [CFG_WIDTH-1:0] start_reg, end_reg;
    logic [AW-1:0]        start_m, end_m;
    logic [AW+CFG_WIDTH-1:0] start_ext, end_ext;
    logic [AW+OUT_ADDR_W-1:0] addr_ext;

    logic [AW-1:0]   addr_reg, addr_next;
    logic [1:0]      step_reg, step_next;
    logic [CW-1:0]   cnt_reg [DATA_WIDTH];
    logic [CW-1:0]   cnt_next [DATA_WIDTH];
    logic [CW-1:0]   total_reg, total_next;
    run_state_t      status_reg, status_next;
    logic            valid_reg, valid_next;

    logic                  pop;
    logic [DATA_WIDTH-1:0] diff, counted;
    logic [3:0]            prefix;
    logic [CW-1:0]         remaining;
    logic [CMPW-1:0]       added;
    logic [CW-1:0]         total_upd;

    assign start_ext = {{AW{1'b0}}, start_reg};
    assign end_ext   = {{AW{1'b0}}, end_reg};
    assign start_m   = start_ext[AW-1:0];
    assign end_m     = end_ext[AW-1:0];

    assign cmd_ready = !valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;

    // bits are counted lowest first until the limit is reached
    always_comb
    begin
        diff      = pattern_of(step_reg) ^ cmd.data;
        remaining = LIMIT - total_reg;
        prefix    = 4'd0;
        added     = '0;
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            counted[b] = diff[b] && (CMPW'(prefix) < CMPW'(remaining));
            prefix     = prefix + {3'd0, diff[b]};
            added      = added + {{(CMPW-1){1'b0}}, counted[b]};
        end
        total_upd = total_reg + added[CW-1:0];
    end

    always_comb
    begin
        addr_next   = addr_reg;
        step_next   = step_reg;
        total_next  = total_reg;
        status_next = status_reg;
        for (int b = 0; b < DATA_WIDTH; b++)
        begin
            cnt_next[b] = cnt_reg[b];
        end
        valid_next = valid_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b0;
        end
        if (pop)
        begin
            valid_next = 1'b1;
            if (cmd.op == OP_START)
            begin
                for (int b = 0; b < DATA_WIDTH; b++)
                begin
                    cnt_next[b] = '0;
                end
                total_next = '0;
                step_next  = 2'd0;
                if (start_m > end_m)
                begin
                    addr_next   = start_m - AW'(1);
                    status_next = RS_CLEAN;
                end
                else
                begin
                    addr_next   = start_m;
                    status_next = RS_RUN;
                end
            end
            else if (status_reg == RS_RUN)
            begin
                for (int b = 0; b < DATA_WIDTH; b++)
                begin
                    cnt_next[b] = cnt_reg[b] + CW'(counted[b]);
                end
                total_next = total_upd;
                step_next  = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    // finishing leaves the address on the last one tested
                    if ((total_upd >= LIMIT) || (addr_reg >= end_m))
                    begin
                        if (total_upd == '0)
                            status_next = RS_CLEAN;
                        else if (total_upd >= LIMIT)
                            status_next = RS_CANCEL;
                        else
                            status_next = RS_ERRORS;
                    end
                    else
                    begin
                        addr_next = addr_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_ADDRESS_RST;
            end_reg    <= END_ADDRESS_RST;
            addr_reg   <= '0;
            step_reg   <= 2'd0;
            total_reg  <= '0;
            status_reg <= RS_IDLE;
            valid_reg  <= 1'b0;
            for (int b = 0; b < DATA_WIDTH; b++)
            begin
                cnt_reg[b] <= '0;
            end
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_START_ADDRESS))
                start_reg <= cfg_wdata;
            if (cfg_we && (cfg_index == CFG_END_ADDRESS))
                end_reg <= cfg_wdata;
            addr_reg   <= addr_next;
            step_reg   <= step_next;
            total_reg  <= total_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
            for (int b = 0; b < DATA_WIDTH; b++)
            begin
                cnt_reg[b] <= cnt_next[b];
            end
        end
    end

    assign addr_ext    = {{OUT_ADDR_W{1'b0}}, addr_reg};
    assign res_valid   = valid_reg;
    assign res_address = addr_ext[OUT_ADDR_W-1:0];
    assign res_pattern = (status_reg == RS_RUN) ? pattern_of(step_reg) : '0;
    assign res_state   = status_reg;

    generate
        if (CW >= OUT_CNT_W)
        begin : g_cnt_trunc
            assign res_total = total_reg[OUT_CNT_W-1:0];
            for (genvar b = 0; b < DATA_WIDTH; b++)
            begin : g_bit
                assign res_bits[b*OUT_CNT_W +: OUT_CNT_W] = cnt_reg[b][OUT_CNT_W-1:0];
            end
        end
        else
        begin : g_cnt_ext
            assign res_total = {{(OUT_CNT_W-CW){1'b0}}, total_reg};
            for (genvar b = 0; b < DATA_WIDTH; b++)
            begin : g_bit
                assign res_bits[b*OUT_CNT_W +: OUT_CNT_W] =
                    {{(OUT_CNT_W-CW){1'b0}}, cnt_reg[b]};
            end
        end
    endgenerate

endmodule

[dv/memory_pattern_test_engine_top_tb.sv]
// self-checking testbench for memory_pattern_test_engine_top: runs over random address ranges,
// random readback errors, a cycle-free behavioral model and random stalls on both streams
// depends on mpte_pkg and memory_pattern_test_engine_top
`timescale 1ns / 100ps

module memory_pattern_test_engine_top_tb;

    import mpte_pkg::*;

    localparam int BIT_LIMIT = 256;
    localparam int TARGET_ITEMS = 2000;
    localparam logic [3:0][7:0] PATTERNS = {8'h55, 8'hAA, 8'hFF, 8'h00};

    // result word as the block packs it, request_address in the lowest bits
    typedef struct packed
    {
        logic [3:0]      pad;
        logic [7:0][8:0] bit_errs;
        logic [8:0]      total;
        logic [2:0]      state;
        logic [7:0]      pattern;
        logic [15:0]     addr;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_START_ADDRESS;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;  // read_data
    logic s_axis_tuser = OP_READBACK;         // action
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // request_address, request_pattern, run_state, total_errors,
    // bit0_errors .. bit7_errors, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    cmd_t    pending_cmds[$];
    result_t expected_status[$];
    cmd_t    next_cmd;
    result_t seen, want;
    bit      item_taken = 1'b0;
    int      mismatches = 0;
    int      run_items = 0;
    int      send_gap_pct = 0;
    int      ready_gap_pct = 0;

    // behavioral copy of the engine
    logic [15:0] start_reg = START_ADDRESS_RST;
    logic [15:0] end_reg = END_ADDRESS_RST;
    logic [16:0] cur_addr = '0;
    logic [1:0]  step = '0;
    logic [8:0]  bit_cnt[8];
    logic [8:0]  err_total = '0;
    run_state_t  status = RS_IDLE;

    memory_pattern_test_engine_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void close_run();
        cur_addr = {1'b0, cur_addr[15:0] - 16'd1};
        if (err_total == 0)
            status = RS_CLEAN;
        else if (err_total >= BIT_LIMIT)
            status = RS_CANCEL;
        else
            status = RS_ERRORS;
    endfunction

    function automatic result_t engine_status(op_t op, logic [7:0] rd);
        logic [7:0] diff;
        result_t r;
        if (op == OP_START)
        begin
            for (int b = 0; b < 8; b++)
                bit_cnt[b] = '0;
            err_total = '0;
            step = '0;
            cur_addr = {1'b0, start_reg};
            status = RS_RUN;
            if (cur_addr > {1'b0, end_reg})
                close_run();
        end
        else if (status == RS_RUN)
        begin
            diff = PATTERNS[step] ^ rd;
            // counting stops at the limit, even part way through a byte
            for (int b = 0; b < 8; b++)
            begin
                if (diff[b] && err_total < BIT_LIMIT)
                begin
                    bit_cnt[b] = bit_cnt[b] + 9'd1;
                    err_total = err_total + 9'd1;
                end
            end
            step = step + 2'd1;
            if (step == 2'd0)
            begin
                cur_addr = cur_addr + 17'd1;
                if (err_total >= BIT_LIMIT || cur_addr > {1'b0, end_reg})
                    close_run();
            end
        end
        r = '0;
        r.addr = cur_addr[15:0];
        r.pattern = (status == RS_RUN) ? PATTERNS[step] : 8'h00;
        r.state = status;
        r.total = err_total;
        for (int b = 0; b < 8; b++)
            r.bit_errs[b] = bit_cnt[b];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    endtask

    // driver: presents queued transactions at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || item_taken))
        begin
            item_taken = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                s_axis_tdata <= next_cmd.data;
                s_axis_tuser <= next_cmd.op;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= ready_gap_pct);
    end

    // monitor: predicts on each accepted command, checks each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                item_taken = 1'b1;
                expected_status.push_back(engine_status(op_t'(s_axis_tuser), s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata;
                if (expected_status.size() == 0)
                begin
                    report_mismatch("result with no transaction pending");
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("request_address", seen.addr, want.addr);
                    check_field("request_pattern", seen.pattern, want.pattern);
                    check_field("run_state", seen.state, want.state);
                    check_field("total_errors", seen.total, want.total);
                    for (int b = 0; b < 8; b++)
                        check_field($sformatf("bit%0d_errors", b), seen.bit_errs[b],
                                    want.bit_errs[b]);
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_START_ADDRESS)
            start_reg = value;
        else
            end_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_cmd(op_t op, logic [7:0] data);
        pending_cmds.push_back('{op: op, data: data});
    endtask

    // readbacks for one address, first nsteps patterns; full flips every bit
    task automatic push_address(int err_pct, bit full, int nsteps);
        logic [7:0] flip;
        for (int s = 0; s < nsteps; s++)
        begin
            flip = 8'h00;
            if ($urandom_range(99) < err_pct)
                flip = full ? 8'hFF : 8'($urandom_range(1, 255));
            push_cmd(OP_READBACK, PATTERNS[s] ^ flip);
            run_items++;
        end
    endtask

    task automatic push_run(int n_addr, int err_pct, bit full, int tail);
        push_cmd(OP_START, 8'($urandom_range(255)));
        run_items++;
        for (int a = 0; a < n_addr; a++)
            push_address(err_pct, full, 4);
        push_address(err_pct, full, tail);
    endtask

    initial
    begin
        int sel;
        int span;
        int n_addr;
        int err_pct;
        logic [15:0] lo, hi;

        for (int b = 0; b < 8; b++)
            bit_cnt[b] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 29;
        ready_gap_pct = 82;

        // readbacks before any run are ignored
        push_cmd(OP_READBACK, 8'h00);
        push_cmd(OP_READBACK, 8'hFF);
        // default range: one clean address, sender holds off, then a fully inverted one
        push_run(1, 0, 1'b0, 0);
        wait_idle();
        push_address(100, 1'b1, 4);
        // restart while running clears the counters
        push_run(0, 0, 1'b0, 1);
        wait_idle();

        // top of the address space: the run ends at 0xFFFF, the address does not wrap
        write_reg(CFG_START_ADDRESS, 16'hFFFF);
        write_reg(CFG_END_ADDRESS, 16'hFFFF);
        push_run(1, 0, 1'b0, 0);
        push_cmd(OP_READBACK, 8'h12);
        wait_idle();

        // start above end finishes at once
        write_reg(CFG_START_ADDRESS, 16'h0001);
        write_reg(CFG_END_ADDRESS, 16'h0000);
        push_run(0, 0, 1'b0, 0);
        wait_idle();

        // error limit reached on the very last bit of the last address
        write_reg(CFG_START_ADDRESS, 16'h0000);
        write_reg(CFG_END_ADDRESS, 16'h0007);
        push_run(8, 100, 1'b1, 0);
        push_cmd(OP_READBACK, 8'hA5);
        wait_idle();

        while (run_items < TARGET_ITEMS)
        begin
            wait_idle();
            if (run_items < TARGET_ITEMS / 3)
            begin
                send_gap_pct = 29;
                ready_gap_pct = 82;
            end
            else if (run_items < 2 * TARGET_ITEMS / 3)
            begin
                send_gap_pct = 82;
                ready_gap_pct = 29;
            end
            else
            begin
                send_gap_pct = 0;
                ready_gap_pct = 0;
            end

            sel = $urandom_range(9);
            case (sel)
                0:
                begin
                    lo = 16'h0000;
                    hi = 16'hFFFF;
                end
                1:
                begin
                    lo = 16'hFFF8;
                    hi = 16'hFFFF;
                end
                2:
                begin
                    lo = 16'($urandom_range(1, 65535));
                    hi = 16'($urandom_range(0, lo - 1));
                end
                default:
                begin
                    lo = 16'($urandom_range(0, 65535));
                    span = int'(lo) + $urandom_range(0, 12);
                    hi = (span > 65535) ? 16'hFFFF : 16'(span);
                end
            endcase
            write_reg(CFG_START_ADDRESS, lo);
            write_reg(CFG_END_ADDRESS, hi);
            span = (hi >= lo) ? int'(hi) - int'(lo) + 1 : 0;
            if (span > 16)
                span = 16;

            repeat ($urandom_range(2, 4))
            begin
                sel = $urandom_range(9);
                case ($urandom_range(3))
                    0: err_pct = 0;
                    1: err_pct = 3;
                    2: err_pct = 25;
                    default: err_pct = 100;
                endcase
                if (sel < 6)
                    n_addr = span;
                else if (sel < 8)
                    n_addr = $urandom_range(0, span);
                else
                    n_addr = span + 1;
                push_run(n_addr, err_pct, $urandom_range(3) == 0,
                         (sel < 6) ? 0 : $urandom_range(0, 3));
                // stray traffic between runs
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(1, 4))
                        push_cmd(op_t'($urandom_range(1)), 8'($urandom_range(255)));
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/mpte_pkg.sv
sv/mpte_front.sv
sv/mpte_back.sv
sv/memory_pattern_test_engine_top.sv
dv/memory_pattern_test_engine_top_tb.sv
